@@ src/overdue_priority_task_scheduler_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the overdue priority task scheduler
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef OVERDUE_PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define OVERDUE_PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define OPTS_ASSERT_NOW(label, clk, rst_n, cond, expect_now, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(cond) |-> (expect_now)) else $error(msg);

// next-cycle implication
`define OPTS_ASSERT_NEXT(label, clk, rst_n, cond, expect_next, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(cond) |=> (expect_next)) else $error(msg);

`endif

@@ src/opts_pkg.sv @@
// ----------------------------------------------------------------------------
// opts_pkg
// Types and constants shared by the task scheduler controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package opts_pkg;

	localparam int DEF_MAX_TASKS = 8;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LIMIT = 2'd2;

	// item kinds
	localparam logic KIND_SCHEDULE = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// grant kinds
	localparam logic [1:0] GRANT_NONE = 2'd0;
	localparam logic [1:0] GRANT_PERIODIC = 2'd1;
	localparam logic [1:0] GRANT_IDLE = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [31:0] tick_now;
		logic        abort_request;
		logic        abort_exception;
		logic [2:0]  task_slot;
		logic [15:0] task_period;
		logic [7:0]  task_priority;
	} in_item_t;

	typedef struct packed {
		logic [1:0] grant_kind;
		logic [2:0] granted_index;
		logic       overflow_fault;
		logic       abort_honored_now;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic load_wr;
		logic scan_rd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic skip_scan;
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

@@ src/opts_ctrl.sv @@
// ----------------------------------------------------------------------------
// opts_ctrl
// Sequencer: takes one item, loads or scans as needed, hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opts_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire opts_pkg::status_t status,
	output opts_pkg::cmd_t        cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.is_load) begin
					cmd.load_wr = 1'b1;
					state_nxt = ST_FIN;
				end else if (status.skip_scan) begin
					state_nxt = ST_FIN;
				end else begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			// last read entry is scored here
			ST_DRAIN: begin
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

@@ src/opts_datapath.sv @@
// ----------------------------------------------------------------------------
// opts_datapath
// Task tables, configuration registers, score scan and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opts_datapath #(
	parameter int MAX_TASKS = opts_pkg::DEF_MAX_TASKS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire opts_pkg::in_item_t                in_data,
	input  wire logic                              cfg_we,
	input  wire logic [opts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [opts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire opts_pkg::cmd_t                    cmd,
	output opts_pkg::status_t                      status,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output opts_pkg::out_item_t                    out_data
);

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	// configuration
	logic [3:0]  per_cnt_q;
	logic [3:0]  idle_cnt_q;
	logic [15:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_cnt_q <= '0;
			idle_cnt_q <= '0;
			limit_q <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				opts_pkg::CFG_PERIODIC_COUNT: per_cnt_q <= cfg_data[3:0];
				opts_pkg::CFG_IDLE_COUNT:     idle_cnt_q <= cfg_data[3:0];
				opts_pkg::CFG_OVERFLOW_LIMIT: limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	logic [3:0] n_cnt;
	logic [3:0] m_cnt;

	assign n_cnt = (32'(per_cnt_q) > MAX_TASKS) ? 4'(MAX_TASKS) : per_cnt_q;
	assign m_cnt = (32'(idle_cnt_q) > MAX_TASKS) ? 4'(MAX_TASKS) : idle_cnt_q;

	// captured item
	opts_pkg::in_item_t item_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	logic          is_load;
	logic          abort_mode;
	logic          slot_ok;
	logic [AW-1:0] load_addr;

	assign is_load = (item_q.kind == opts_pkg::KIND_LOAD);
	assign abort_mode = item_q.abort_request & item_q.abort_exception;
	assign slot_ok = (32'(item_q.task_slot) < MAX_TASKS);
	assign load_addr = AW'(item_q.task_slot);

	// scan state
	logic [AW-1:0] scan_idx_q;
	logic          found_q;
	logic [16:0]   best_q;
	logic [AW-1:0] best_idx_q;
	logic          fault_q;

	// task tables; an entry never written reads as zero
	logic [31:0]          last_mem [MAX_TASKS];
	logic [23:0]          pp_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] last_vld_q;
	logic [MAX_TASKS-1:0] pp_vld_q;

	logic          last_we;
	logic [AW-1:0] last_wa;
	logic          pp_we;

	assign pp_we = cmd.load_wr && slot_ok;
	assign last_we = pp_we || (cmd.finish && found_q);
	assign last_wa = cmd.load_wr ? load_addr : best_idx_q;

	logic [31:0]   last_rd_s1;
	logic [23:0]   pp_rd_s1;
	logic          lv_s1;
	logic          pv_s1;
	logic [AW-1:0] idx_s1;
	logic          rd_s1;

	always_ff @(posedge clk) begin
		if (last_we) begin
			last_mem[last_wa] <= item_q.tick_now;
		end
		if (pp_we) begin
			pp_mem[load_addr] <= {item_q.task_period, item_q.task_priority};
		end
		if (cmd.scan_rd) begin
			last_rd_s1 <= last_mem[scan_idx_q];
			pp_rd_s1 <= pp_mem[scan_idx_q];
			lv_s1 <= last_vld_q[scan_idx_q];
			pv_s1 <= pp_vld_q[scan_idx_q];
			idx_s1 <= scan_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_vld_q <= '0;
			pp_vld_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.scan_rd;
			if (last_we) begin
				last_vld_q[last_wa] <= 1'b1;
			end
			if (pp_we) begin
				pp_vld_q[load_addr] <= 1'b1;
			end
		end
	end

	// score one entry
	logic [31:0] last_v;
	logic [15:0] per_v;
	logic [7:0]  pri_v;
	logic [31:0] elapsed;
	logic [15:0] lo;
	logic        overdue;
	logic [16:0] score;
	logic        ovf;
	logic        take;

	always_comb begin
		last_v = lv_s1 ? last_rd_s1 : '0;
		per_v = pv_s1 ? pp_rd_s1[23:8] : '0;
		pri_v = pv_s1 ? pp_rd_s1[7:0] : '0;
		elapsed = item_q.tick_now - last_v;
		lo = elapsed[15:0];
		overdue = lo > per_v;
		score = 17'(lo) - 17'(per_v) + 17'(pri_v);
		ovf = (|elapsed[31:16]) || (lo > limit_q);
		take = overdue && (!found_q || (score > best_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_idx_q <= '0;
			fault_q <= 1'b0;
		end else if (cmd.capture) begin
			scan_idx_q <= '0;
			found_q <= 1'b0;
			fault_q <= 1'b0;
		end else begin
			if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + AW'(1);
			end
			if (rd_s1) begin
				if (ovf) begin
					fault_q <= 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
					best_q <= score;
					best_idx_q <= idx_s1;
				end
			end
		end
	end

	// result and idle round robin
	logic [3:0]          ptr_q;
	logic                honored_q;
	logic                out_valid_q;
	opts_pkg::out_item_t out_q;

	logic [3:0]          ptr_sel;
	logic [3:0]          ptr_inc;
	logic [3:0]          ptr_nxt;
	opts_pkg::out_item_t res;
	logic                honored_now;

	always_comb begin
		ptr_sel = (ptr_q < m_cnt) ? ptr_q : '0;
		ptr_inc = ptr_sel + 4'd1;
		ptr_nxt = (ptr_inc >= m_cnt) ? '0 : ptr_inc;
		honored_now = !is_load && abort_mode && !honored_q;
		res = '0;
		if (!is_load) begin
			if (found_q) begin
				res.grant_kind = opts_pkg::GRANT_PERIODIC;
				res.granted_index = 3'(best_idx_q);
			end else if (m_cnt != 4'd0) begin
				res.grant_kind = opts_pkg::GRANT_IDLE;
				res.granted_index = 3'(ptr_sel);
			end
			res.overflow_fault = fault_q;
			res.abort_honored_now = honored_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			honored_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
			if (!is_load && !found_q) begin
				ptr_q <= (m_cnt == 4'd0) ? '0 : ptr_nxt;
			end
			if (honored_now) begin
				honored_q <= 1'b1;
			end
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign status.is_load = is_load;
	assign status.skip_scan = abort_mode || (n_cnt == 4'd0);
	assign status.scan_last = ((32'(scan_idx_q) + 32'd1) == 32'(n_cnt));
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

@@ src/overdue_priority_task_scheduler.sv @@
// Load item: the beat is checked, written to the tables, then the result registered.
// Schedule item: n table entries are scanned and scored, then the result is registered;
// n = periodic task count (clamped to MAX_TASKS); the single read port of the task tables
// scans one entry a cycle. Items in abort mode or with no periodic tasks skip the scan.
// The next item is taken the cycle after the result lands in the output register.
// Reset clears control, counts, idle pointer and abort flag; tables read as zero.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// overdue_priority_task_scheduler
// Grants the overdue periodic task with most lateness plus priority, else idle round robin.
// ----------------------------------------------------------------------------
`include "overdue_priority_task_scheduler_assert.svh"

module overdue_priority_task_scheduler #(
	parameter int MAX_TASKS = opts_pkg::DEF_MAX_TASKS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire opts_pkg::in_item_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output opts_pkg::out_item_t                  out_data,
	input  wire logic                            cfg_we,
	input  wire logic [opts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [opts_pkg::CFG_DATA_W-1:0] cfg_data
);

	opts_pkg::cmd_t    cmd;
	opts_pkg::status_t status;

	opts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	opts_datapath #(
		.MAX_TASKS (MAX_TASKS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a finished result never overwrites one still waiting
	`OPTS_ASSERT_NOW(a_finish_free, clk, arst_n, cmd.finish, status.out_free, "result overwritten")
	// scan stops after the last entry
	`OPTS_ASSERT_NEXT(a_scan_stop, clk, arst_n, cmd.scan_rd && status.scan_last, !cmd.scan_rd, "scan overran")
	// one item in flight
	`OPTS_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && !in_stall, in_stall, "second beat taken")

endmodule

`default_nettype wire
